// File: sv/fresnel_dielectric_reflectance_macros.svh
// Assertion macros for the Fresnel reflectance block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef FRESNEL_DIELECTRIC_REFLECTANCE_MACROS_SVH
`define FRESNEL_DIELECTRIC_REFLECTANCE_MACROS_SVH
`ifndef ASSERT_OFF
`define FDR_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("fdr assertion failed");
`define FDR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("fdr assertion failed");
`else
`define FDR_ASSERT(lbl, clk, rstn, prop)
`define FDR_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: sv/fdr_pkg.sv
// Types and constants shared by the Fresnel reflectance pipeline.
// No dependencies.
package fdr_pkg;

  localparam logic [15:0] OneQ12 = 16'd4096;
  localparam logic [15:0] OneQ15 = 16'h8000;
  localparam logic [30:0] OneQ30 = 31'h4000_0000;
  localparam logic [62:0] OneQ54 = 63'd1 << 54;
  localparam logic [16:0] OneRatio = 17'h1_0000;
  localparam logic [33:0] HalfLsb = 34'd1 << 17;

  localparam int QW = 31;
  localparam int RatioW = 17;

  // sideband through the transmitted cos^2 divider
  typedef struct packed {
    logic        outside;
    logic        eta_one;
    logic        tir;
    logic [15:0] ci;
    logic [15:0] eta;
    logic [30:0] qin;
  } q_side_t;

  // sideband through the square root
  typedef struct packed {
    logic        outside;
    logic        eta_one;
    logic        tir;
    logic [15:0] ci;
    logic [15:0] eta;
  } s_side_t;

  // sideband through the amplitude ratio dividers
  typedef struct packed {
    logic        outside;
    logic        eta_one;
    logic        tir;
    logic [15:0] t;
    logic        den_zero;
  } r_side_t;

endpackage

// File: sv/fresnel_dielectric_reflectance.sv
//  channel | direction | handshake               | payload
//  in      | sink      | in_valid_i / in_ready_o | cos_incident_i, eta_i
//  out     | source    | out_valid_o/out_ready_i | reflectance_o, cos_transmitted_o,
//          |           |                         | total_reflection_o
// One beat per cycle sustained while out_ready_i holds; the path runs through the 31-stage cos^2
// divider, the 16-stage square root and the 17-stage ratio dividers in series.
// Reset clears only the stage valid bits. A stall at the output freezes every
// stage together; bubbles stay in place.
// Top level of the Fresnel reflectance pipeline; uses fdr_pkg, fdr_div, fdr_sqrt and the macros header.
module fresnel_dielectric_reflectance (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] cos_incident_i,
  input  logic [15:0] eta_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] reflectance_o,
  output logic [15:0] cos_transmitted_o,
  output logic        total_reflection_o
);
  import fdr_pkg::*;
  `include "fresnel_dielectric_reflectance_macros.svh"

  logic adv;
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  // stage A: magnitude and squares
  logic        va_q;
  logic [15:0] ci_a_q, e_a_q;
  logic        out_a_q;
  logic [30:0] cisq_a_q;
  logic [31:0] e2_a_q;
  logic [15:0] ci_a_d;
  logic [31:0] cisq_a_d;

  assign ci_a_d   = cos_incident_i[15] ? 16'(~cos_incident_i + 16'd1) : cos_incident_i;
  assign cisq_a_d = ci_a_d * ci_a_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (adv) begin
      va_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ci_a_q   <= ci_a_d;
      e_a_q    <= eta_i;
      out_a_q  <= !cos_incident_i[15] && (cos_incident_i != 16'd0);
      cisq_a_q <= cisq_a_d[30:0];
      e2_a_q   <= eta_i * eta_i;
    end
  end

  // stage B: sin^2, its product with eta^2, outside-ray difference
  logic        vb_q;
  logic [15:0] ci_b_q, e_b_q;
  logic        out_b_q, tiro_b_q;
  logic [62:0] prod_b_q;
  logic [37:0] x_b_q;
  logic [31:0] e2_b_q;
  logic [30:0] sin2_b;
  logic [37:0] e64_b;

  assign sin2_b = OneQ30 - cisq_a_q;
  assign e64_b  = {e2_a_q, 6'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (adv) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ci_b_q   <= ci_a_q;
      e_b_q    <= e_a_q;
      out_b_q  <= out_a_q;
      e2_b_q   <= e2_a_q;
      prod_b_q <= sin2_b * e2_a_q;
      tiro_b_q <= {7'b0, sin2_b} >= e64_b;
      x_b_q    <= e64_b - {7'b0, sin2_b};
    end
  end

  // stage C: inside-ray cos^2 and total reflection test
  logic        vc_q;
  logic [37:0] x_c_q;
  logic [31:0] e2_c_q;
  q_side_t     qs_c_q;
  q_side_t     qs_c_d;
  logic [62:0] rin_c;

  assign rin_c = OneQ54 - prod_b_q;

  always_comb begin
    qs_c_d.outside = out_b_q;
    qs_c_d.eta_one = e_b_q == OneQ12;
    qs_c_d.tir     = out_b_q ? tiro_b_q : (prod_b_q >= OneQ54);
    qs_c_d.ci      = ci_b_q;
    qs_c_d.eta     = e_b_q;
    qs_c_d.qin     = rin_c[54:24];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (adv) begin
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_c_q  <= x_b_q;
      e2_c_q <= e2_b_q;
      qs_c_q <= qs_c_d;
    end
  end

  // cos^2 of transmission for rays from outside: (x << 24) / eta^2
  logic          vq;
  logic [QW-1:0] quo_q;
  q_side_t       qs_q;

  fdr_div #(.DW(32), .QW(QW), .SW($bits(q_side_t))) u_qdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vc_q),
    .rem_i   ({1'b0, x_c_q[37:7]}),
    .div_i   (e2_c_q),
    .low_i   ({x_c_q[6:0], 24'b0}),
    .side_i  (qs_c_q),
    .valid_o (vq),
    .quo_o   (quo_q),
    .side_o  (qs_q)
  );

  logic [30:0] q_sel;
  s_side_t     ss_in, ss_out;
  logic        vs;
  logic [15:0] root;

  assign q_sel          = qs_q.outside ? quo_q : qs_q.qin;
  assign ss_in.outside  = qs_q.outside;
  assign ss_in.eta_one  = qs_q.eta_one;
  assign ss_in.tir      = qs_q.tir;
  assign ss_in.ci       = qs_q.ci;
  assign ss_in.eta      = qs_q.eta;

  fdr_sqrt #(.SW($bits(s_side_t))) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vq),
    .rad_i   ({1'b0, q_sel}),
    .side_i  (ss_in),
    .valid_o (vs),
    .root_o  (root),
    .side_o  (ss_out)
  );

  // stage E: operands of the two amplitude ratios
  logic        ve_q;
  logic [31:0] n1_e_q, d1_e_q, n2_e_q, d2_e_q;
  logic [15:0] t_e_q;
  logic        out_e_q, one_e_q, tir_e_q;
  logic [15:0] t_e;

  // with unit eta the transmitted cosine is just the incident one
  assign t_e = ss_out.eta_one ? ss_out.ci : root;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ve_q <= 1'b0;
    end else if (adv) begin
      ve_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n1_e_q  <= {4'b0, ss_out.ci, 12'b0};
      d1_e_q  <= ss_out.eta * t_e;
      n2_e_q  <= ss_out.eta * ss_out.ci;
      d2_e_q  <= {4'b0, t_e, 12'b0};
      t_e_q   <= t_e;
      out_e_q <= ss_out.outside;
      one_e_q <= ss_out.eta_one;
      tir_e_q <= ss_out.tir;
    end
  end

  // stage F: |n - d| and n + d
  logic        vf_q;
  logic [31:0] num1_f_q, den1_f_q, num2_f_q, den2_f_q;
  r_side_t     rs_f_q;
  logic        z2_f_q;
  logic [32:0] den1_f, den2_f;

  assign den1_f = {1'b0, n1_e_q} + {1'b0, d1_e_q};
  assign den2_f = {1'b0, n2_e_q} + {1'b0, d2_e_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else if (adv) begin
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      num1_f_q         <= (n1_e_q >= d1_e_q) ? n1_e_q - d1_e_q : d1_e_q - n1_e_q;
      num2_f_q         <= (n2_e_q >= d2_e_q) ? n2_e_q - d2_e_q : d2_e_q - n2_e_q;
      den1_f_q         <= den1_f[31:0];
      den2_f_q         <= den2_f[31:0];
      rs_f_q.outside   <= out_e_q;
      rs_f_q.eta_one   <= one_e_q;
      rs_f_q.tir       <= tir_e_q;
      rs_f_q.t         <= t_e_q;
      rs_f_q.den_zero  <= den1_f[31:0] == 32'd0;
      z2_f_q           <= den2_f[31:0] == 32'd0;
    end
  end

  // amplitude ratios in Q1.16: (num << 16) / den
  logic              vr;
  logic              vr2;
  logic [RatioW-1:0] quo1, quo2;
  r_side_t           rs_r;
  logic              z2_r;

  fdr_div #(.DW(32), .QW(RatioW), .SW($bits(r_side_t))) u_rsdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vf_q),
    .rem_i   ({1'b0, num1_f_q[31:1]}),
    .div_i   (den1_f_q),
    .low_i   ({num1_f_q[0], 16'b0}),
    .side_i  (rs_f_q),
    .valid_o (vr),
    .quo_o   (quo1),
    .side_o  (rs_r)
  );

  fdr_div #(.DW(32), .QW(RatioW), .SW(1)) u_rpdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vf_q),
    .rem_i   ({1'b0, num2_f_q[31:1]}),
    .div_i   (den2_f_q),
    .low_i   ({num2_f_q[0], 16'b0}),
    .side_i  (z2_f_q),
    .valid_o (vr2),
    .quo_o   (quo2),
    .side_o  (z2_r)
  );

  // stage G: squares of the ratios
  logic        vg_q;
  logic [33:0] rs2_g_q, rp2_g_q;
  r_side_t     rs_g_q;
  logic [16:0] rs_sel, rp_sel;

  assign rs_sel = rs_r.den_zero ? OneRatio : quo1;
  assign rp_sel = z2_r ? OneRatio : quo2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vg_q <= 1'b0;
    end else if (adv) begin
      vg_q <= vr && vr2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rs2_g_q <= rs_sel * rs_sel;
      rp2_g_q <= rp_sel * rp_sel;
      rs_g_q  <= rs_r;
    end
  end

  // stage H: round, pick the special cases, output register
  logic        vh_q;
  logic [15:0] refl_h_q, cos_h_q;
  logic        tir_h_q;
  logic [33:0] sum_h;
  logic [15:0] refl_h_d, cos_h_d, cos_norm;
  logic        tir_h_d;

  assign sum_h    = rs2_g_q + rp2_g_q + HalfLsb;
  assign cos_norm = rs_g_q.outside ? 16'(~rs_g_q.t + 16'd1)
                                   : (rs_g_q.t[15] ? 16'h7FFF : rs_g_q.t);

  always_comb begin
    refl_h_d = sum_h[33:18];
    cos_h_d  = cos_norm;
    tir_h_d  = 1'b0;
    if (rs_g_q.eta_one) begin
      refl_h_d = '0;
    end else if (rs_g_q.tir) begin
      refl_h_d = OneQ15;
      cos_h_d  = '0;
      tir_h_d  = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vh_q <= 1'b0;
    end else if (adv) begin
      vh_q <= vg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      refl_h_q <= refl_h_d;
      cos_h_q  <= cos_h_d;
      tir_h_q  <= tir_h_d;
    end
  end

  assign out_valid_o        = vh_q;
  assign reflectance_o      = refl_h_q;
  assign cos_transmitted_o  = cos_h_q;
  assign total_reflection_o = tir_h_q;

  `FDR_ASSERT(a_tir_shape, clk_i, rst_ni, out_valid_o && total_reflection_o |-> reflectance_o == OneQ15 && cos_transmitted_o == 16'd0)
  `FDR_ASSERT(a_refl_range, clk_i, rst_ni, out_valid_o |-> reflectance_o <= OneQ15)
  `FDR_ASSERT(a_ratio_lanes_aligned, clk_i, rst_ni, vr == vr2)
  `FDR_ASSERT_ALWAYS(a_ready_when_empty, clk_i, !out_valid_o |-> in_ready_o)

endmodule

// File: sv/fdr_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Standalone; sideband bits ride along with each item.
module fdr_div #(
  parameter int DW = 32,
  parameter int QW = 17,
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [DW-1:0] rem_i,
  input  logic [DW-1:0] div_i,
  input  logic [QW-1:0] low_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output logic [SW-1:0] side_o
);

  logic [DW-1:0] rem_q  [QW];
  logic [DW-1:0] div_q  [QW];
  logic [QW-1:0] lq_q   [QW];
  logic [SW-1:0] side_q [QW];
  logic          vld_q  [QW];

  genvar k;
  generate
    for (k = 0; k < QW; k++) begin : g_stage
      logic [DW-1:0] r_in;
      logic [DW-1:0] d_in;
      logic [QW-1:0] lq_in;
      logic [SW-1:0] s_in;
      logic          v_in;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          ge;

      if (k == 0) begin : g_first
        assign r_in  = rem_i;
        assign d_in  = div_i;
        assign lq_in = low_i;
        assign s_in  = side_i;
        assign v_in  = valid_i;
      end else begin : g_next
        assign r_in  = rem_q[k-1];
        assign d_in  = div_q[k-1];
        assign lq_in = lq_q[k-1];
        assign s_in  = side_q[k-1];
        assign v_in  = vld_q[k-1];
      end

      // low bits shift out at the top while quotient bits shift in below
      assign trial = {r_in, lq_in[QW-1]};
      assign diff  = trial - {1'b0, d_in};
      assign ge    = trial >= {1'b0, d_in};

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (en_i) begin
          vld_q[k] <= v_in;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
          div_q[k]  <= d_in;
          lq_q[k]   <= {lq_in[QW-2:0], ge};
          side_q[k] <= s_in;
        end
      end
    end
  endgenerate

  assign valid_o = vld_q[QW-1];
  assign quo_o   = lq_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// File: sv/fdr_sqrt.sv
// Pipelined integer square root, one root bit per stage (16 stages).
// Takes a 32-bit radicand; sideband bits ride along with each item.
module fdr_sqrt #(
  parameter int SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [31:0]   rad_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [15:0]   root_o,
  output logic [SW-1:0] side_o
);

  localparam int Steps = 16;

  logic [17:0]   rem_q  [Steps];
  logic [31:0]   rad_q  [Steps];
  logic [15:0]   root_q [Steps];
  logic [SW-1:0] side_q [Steps];
  logic          vld_q  [Steps];

  genvar k;
  generate
    for (k = 0; k < Steps; k++) begin : g_stage
      logic [17:0]   r_in;
      logic [31:0]   x_in;
      logic [15:0]   s_in;
      logic [SW-1:0] sd_in;
      logic          v_in;
      logic [19:0]   cat;
      logic [19:0]   trial;
      logic [19:0]   diff;
      logic          ge;

      if (k == 0) begin : g_first
        assign r_in  = '0;
        assign x_in  = rad_i;
        assign s_in  = '0;
        assign sd_in = side_i;
        assign v_in  = valid_i;
      end else begin : g_next
        assign r_in  = rem_q[k-1];
        assign x_in  = rad_q[k-1];
        assign s_in  = root_q[k-1];
        assign sd_in = side_q[k-1];
        assign v_in  = vld_q[k-1];
      end

      assign cat   = {r_in, x_in[31:30]};
      assign trial = {2'b00, s_in, 2'b01};
      assign diff  = cat - trial;
      assign ge    = cat >= trial;

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          vld_q[k] <= 1'b0;
        end else if (en_i) begin
          vld_q[k] <= v_in;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k]  <= ge ? diff[17:0] : cat[17:0];
          rad_q[k]  <= {x_in[29:0], 2'b00};
          root_q[k] <= {s_in[14:0], ge};
          side_q[k] <= sd_in;
        end
      end
    end
  endgenerate

  assign valid_o = vld_q[Steps-1];
  assign root_o  = root_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

// File: tb/sv/tb_top.sv
// Testbench for fresnel_dielectric_reflectance: random and directed beats,
// predicted reflectance and transmitted cosine checked in order.
// Depends on the block RTL and fdr_pkg only.
`timescale 1ns / 100ps

class fresnel_scoreboard;
  typedef struct {
    logic [15:0] refl;
    logic [15:0] cos_t;
    logic        tir;
  } fresnel_result_t;

  fresnel_result_t pending_q[$];
  int errors;

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] amp_ratio(logic [63:0] n, logic [63:0] d);
    logic [63:0] num;
    logic [63:0] den;
    num = (n >= d) ? n - d : d - n;
    den = n + d;
    if (den == 0) return 64'd65536;
    return (num << 16) / den;
  endfunction

  function automatic logic [15:0] clamp_cos(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic fresnel_result_t fresnel_predict(logic [15:0] cin, logic [15:0] eta);
    fresnel_result_t r;
    longint c;
    logic outside;
    logic [63:0] ci, sin2, e, e2, q, t, rs, rp, sum;
    logic tir;
    c = longint'($signed(cin));
    outside = c > 0;
    ci = (c < 0) ? -c : c;
    sin2 = 64'd1073741824 - ci * ci;
    e = 64'(eta);
    e2 = e * e;
    if (eta == fdr_pkg::OneQ12) begin
      r.refl = '0;
      r.cos_t = clamp_cos(-c);
      r.tir = 1'b0;
      return r;
    end
    if (outside) tir = sin2 >= 64 * e2;
    else tir = sin2 * e2 >= (64'd1 << 54);
    if (tir) begin
      r.refl = fdr_pkg::OneQ15;
      r.cos_t = '0;
      r.tir = 1'b1;
      return r;
    end
    if (outside) q = ((64 * e2 - sin2) << 24) / e2;
    else q = ((64'd1 << 54) - sin2 * e2) >> 24;
    t = int_sqrt(q);
    rs = amp_ratio(ci * 4096, e * t);
    rp = amp_ratio(e * ci, t * 4096);
    sum = rs * rs + rp * rp;
    r.refl = 16'((sum + (64'd1 << 17)) >> 18);
    r.cos_t = clamp_cos(outside ? -longint'(t) : longint'(t));
    r.tir = 1'b0;
    return r;
  endfunction

  function void note_input(logic [15:0] cin, logic [15:0] eta);
    pending_q.insert(pending_q.size(), fresnel_predict(cin, eta));
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_result(logic [15:0] refl, logic [15:0] cos_t, logic tir);
    fresnel_result_t x;
    if (pending_q.size() == 0) begin
      report("result with nothing pending");
      return;
    end
    x = pending_q.pop_front();
    if (refl !== x.refl)
      report($sformatf("reflectance got %0d exp %0d", refl, x.refl));
    if (cos_t !== x.cos_t)
      report($sformatf("cos_transmitted got %0h exp %0h", cos_t, x.cos_t));
    if (tir !== x.tir)
      report($sformatf("total_reflection got %0b exp %0b", tir, x.tir));
  endtask
endclass

module tb_top;
  localparam int Latency = 71;
  localparam int WatchdogLimit = 20000;
  localparam int RandomBeats = 800;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [15:0] cos_incident_i = 16'd0;
  logic [15:0] eta_i = 16'd4096;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [15:0] reflectance_o;
  logic [15:0] cos_transmitted_o;
  logic        total_reflection_o;

  fresnel_scoreboard sb;
  logic calm = 1'b0;
  logic src_done = 1'b0;
  int   idle_cycles = 0;

  fresnel_dielectric_reflectance dut (.*);

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    sb = new();
    rst_ni = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
  end

  // Hold valid and payload until the beat is taken.
  task automatic send_beat(logic [15:0] cin, logic [15:0] eta);
    while (!calm && $urandom_range(99) < 24) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    cos_incident_i <= cin;
    eta_i <= eta;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_input(cin, eta);
  endtask

  function automatic logic [15:0] pick_eta();
    case ($urandom_range(7))
      0: return 16'd4096;
      1: return 16'($urandom_range(3000, 6000));
      2: return 16'($urandom_range(0, 255));
      3: return 16'($urandom_range(60000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_cos();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'h8000 | 16'($urandom_range(0, 7));
      2: return 16'($urandom_range(32760, 32767));
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] dir_cos[8];
    logic [15:0] dir_eta[3];
    dir_cos = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'hFFFF, 16'h4000,
                16'hC000, 16'h2000};
    dir_eta = '{16'd4096, 16'd6144, 16'd2731};
    @(posedge rst_ni);
    @(posedge clk_i);
    foreach (dir_cos[i]) send_beat(dir_cos[i], dir_eta[i % 3]);
    send_beat(16'h4000, 16'd0);
    send_beat(16'hC000, 16'd0);
    send_beat(16'h0000, 16'd0);
    send_beat(16'h7FFF, 16'hFFFF);
    send_beat(16'h8000, 16'hFFFF);
    send_beat(16'h8000, 16'd4096);
    send_beat(16'h1000, 16'd1);
    send_beat(16'h5555, 16'hAAAA);
    send_beat(16'hAAAA, 16'h5555);
    for (int n = 0; n < RandomBeats; n++) begin
      calm = (n >= 300 && n < 400);
      send_beat(pick_cos(), pick_eta());
    end
    in_valid_i <= 0;
    src_done = 1;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= calm || ($urandom_range(99) >= 24);
      if (out_valid_o && out_ready_i)
        sb.check_result(reflectance_o, cos_transmitted_o, total_reflection_o);
    end
  end

  // Watchdog: count cycles with no beat on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge rst_ni);
    while (!(src_done && sb.pending_q.size() == 0) &&
           idle_cycles < WatchdogLimit)
      @(posedge clk_i);
    if (idle_cycles >= WatchdogLimit) begin
      $display("tb_top: FAIL");
    end else begin
      repeat (Latency + 10) @(posedge clk_i);
      if (sb.errors == 0)
        $display("tb_top: PASS");
      else
        $display("tb_top: FAIL");
    end
    $finish;
  end
endmodule

// File: files.f
+incdir+sv
sv/fdr_pkg.sv
sv/fdr_div.sv
sv/fdr_sqrt.sv
sv/fresnel_dielectric_reflectance.sv
tb/sv/tb_top.sv
